// ===== hdl/acep_pkg.sv =====
package acep_pkg;

	localparam int unsigned QueueDepth = 4;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ESC  = 2'd1,
		PH_CSI  = 2'd2
	} phase_t;

	typedef enum logic [3:0] {
		OP_PUT     = 4'd0,
		OP_UP      = 4'd1,
		OP_DOWN    = 4'd2,
		OP_RIGHT   = 4'd3,
		OP_LEFT    = 4'd4,
		OP_GOTO    = 4'd5,
		OP_CLEAR   = 4'd6,
		OP_EOL     = 4'd7,
		OP_SAVE    = 4'd8,
		OP_RESTORE = 4'd9
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] char_out;
		logic [7:0] move_count;
		logic [7:0] goto_column;
		logic [7:0] goto_row;
		logic [7:0] attribute;
	} cmd_t;

	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_ESC   = 8'd27;
	localparam logic [7:0] CH_LBRK  = 8'h5b;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP    = 8'h41;
	localparam logic [7:0] CH_DOWN  = 8'h42;
	localparam logic [7:0] CH_RIGHT = 8'h43;
	localparam logic [7:0] CH_LEFT  = 8'h44;
	localparam logic [7:0] CH_GOTO  = 8'h48;
	localparam logic [7:0] CH_CLEAR = 8'h4a;
	localparam logic [7:0] CH_EOL   = 8'h4b;
	localparam logic [7:0] CH_SGR   = 8'h6d;
	localparam logic [7:0] CH_SAVE  = 8'h73;
	localparam logic [7:0] CH_REST  = 8'h75;

	localparam logic [7:0] ATTR_RESET = 8'h07;
	localparam logic [7:0] ATTR_FG    = 8'h07;
	localparam logic [7:0] ATTR_BOLD  = 8'h08;
	localparam logic [7:0] ATTR_BG    = 8'h70;
	localparam logic [7:0] ATTR_BLINK = 8'h80;
	localparam logic [7:0] ATTR_COLS  = 8'h77;

	localparam logic [7:0] SGR_RESET   = 8'd0;
	localparam logic [7:0] SGR_BOLD    = 8'd1;
	localparam logic [7:0] SGR_FAINT   = 8'd2;
	localparam logic [7:0] SGR_ULINE   = 8'd4;
	localparam logic [7:0] SGR_BLINK   = 8'd5;
	localparam logic [7:0] SGR_REVERSE = 8'd7;
	localparam logic [7:0] SGR_NOBOLD1 = 8'd21;
	localparam logic [7:0] SGR_NOBOLD2 = 8'd22;
	localparam logic [7:0] SGR_NOBLINK = 8'd25;
	localparam logic [7:0] SGR_FG_LO   = 8'd30;
	localparam logic [7:0] SGR_FG_HI   = 8'd37;
	localparam logic [7:0] SGR_BG_LO   = 8'd40;
	localparam logic [7:0] SGR_BG_HI   = 8'd47;

	// ansi colour order to display colour order
	function automatic logic [2:0] color_map(input logic [2:0] idx);
		logic [2:0] c;
		unique case (idx)
			3'd0: c = 3'd0;
			3'd1: c = 3'd4;
			3'd2: c = 3'd2;
			3'd3: c = 3'd6;
			3'd4: c = 3'd1;
			3'd5: c = 3'd5;
			3'd6: c = 3'd3;
			default: c = 3'd7;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] apply_sgr(input logic [7:0] attr, input logic [7:0] code);
		logic [7:0] a;
		logic [2:0] fg_idx;
		logic [2:0] bg_idx;
		a = attr;
		fg_idx = 3'(code - SGR_FG_LO);
		bg_idx = 3'(code - SGR_BG_LO);
		case (code) inside
			SGR_RESET: a = ATTR_RESET;
			SGR_BOLD: a = attr | ATTR_BOLD;
			SGR_FAINT, SGR_NOBOLD1, SGR_NOBOLD2: a = attr & ~ATTR_BOLD;
			SGR_ULINE: a = (attr & ~ATTR_FG) | 8'h01;
			SGR_BLINK: a = attr | ATTR_BLINK;
			SGR_REVERSE: a = (attr & ~ATTR_COLS) | {1'b0, attr[2:0], 1'b0, attr[6:4]};
			SGR_NOBLINK: a = attr & ~ATTR_BLINK;
			[SGR_FG_LO:SGR_FG_HI]: a = (attr & ~ATTR_FG) | {5'd0, color_map(fg_idx)};
			[SGR_BG_LO:SGR_BG_HI]: a = (attr & ~ATTR_BG) | {1'b0, color_map(bg_idx), 4'd0};
			default: a = attr;
		endcase
		return a;
	endfunction

endpackage

// ===== hdl/acep_front.sv =====
module acep_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         byte_in,
	input  logic               string_start,
	output logic               emit,
	output acep_pkg::cmd_t     cmd
);

	acep_pkg::phase_t phase_q, phase_e, phase_n;
	logic [7:0] committed_q, committed_n;
	logic [7:0] shadow_q, shadow_e, shadow_n;
	logic [7:0] field_q, field_e, field_n;
	logic [7:0] first_q, first_e, first_n;
	logic [7:0] second_q, second_e, second_n;
	logic [1:0] index_q, index_e, index_n;
	logic [11:0] acc;
	logic [7:0] sgr_attr;
	logic [7:0] first_fin;
	logic [7:0] second_fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= acep_pkg::PH_IDLE;
			committed_q <= acep_pkg::ATTR_RESET;
			shadow_q    <= acep_pkg::ATTR_RESET;
			field_q     <= 8'd0;
			first_q     <= 8'd0;
			second_q    <= 8'd0;
			index_q     <= 2'd0;
		end else if (accept) begin
			phase_q     <= phase_n;
			committed_q <= committed_n;
			shadow_q    <= shadow_n;
			field_q     <= field_n;
			first_q     <= first_n;
			second_q    <= second_n;
			index_q     <= index_n;
		end
	end

	always_comb begin
		// a new string drops any half-parsed sequence first
		phase_e  = string_start ? acep_pkg::PH_IDLE : phase_q;
		shadow_e = string_start ? committed_q : shadow_q;
		field_e  = string_start ? 8'd0 : field_q;
		first_e  = string_start ? 8'd0 : first_q;
		second_e = string_start ? 8'd0 : second_q;
		index_e  = string_start ? 2'd0 : index_q;

		acc = {1'b0, field_e, 3'd0} + {3'd0, field_e, 1'b0} + {4'd0, byte_in - acep_pkg::CH_ZERO};
		sgr_attr   = acep_pkg::apply_sgr(shadow_e, field_e);
		first_fin  = (index_e == 2'd0) ? field_e : first_e;
		second_fin = (index_e == 2'd1) ? field_e : second_e;

		phase_n     = phase_e;
		committed_n = committed_q;
		shadow_n    = shadow_e;
		field_n     = field_e;
		first_n     = first_e;
		second_n    = second_e;
		index_n     = index_e;

		emit = 1'b0;
		cmd.op          = acep_pkg::OP_PUT;
		cmd.char_out    = 8'd0;
		cmd.move_count  = 8'd0;
		cmd.goto_column = 8'd0;
		cmd.goto_row    = 8'd0;
		cmd.attribute   = committed_q;

		if (byte_in != acep_pkg::CH_CR) begin
			unique case (phase_e)
				acep_pkg::PH_IDLE: begin
					if (byte_in == acep_pkg::CH_ESC) begin
						phase_n = acep_pkg::PH_ESC;
					end else begin
						emit = 1'b1;
						cmd.char_out = byte_in;
					end
				end
				acep_pkg::PH_ESC: begin
					if (byte_in == acep_pkg::CH_LBRK) begin
						phase_n  = acep_pkg::PH_CSI;
						shadow_n = committed_q;
						field_n  = 8'd0;
						first_n  = 8'd0;
						second_n = 8'd0;
						index_n  = 2'd0;
					end else if (byte_in != acep_pkg::CH_ESC) begin
						phase_n = acep_pkg::PH_IDLE;
					end
				end
				acep_pkg::PH_CSI: begin
					if (byte_in >= acep_pkg::CH_ZERO && byte_in <= acep_pkg::CH_NINE) begin
						field_n = (acc > 12'd255) ? 8'd255 : acc[7:0];
					end else if (byte_in == acep_pkg::CH_SEMI) begin
						first_n  = first_fin;
						second_n = second_fin;
						shadow_n = sgr_attr;
						field_n  = 8'd0;
						index_n  = (index_e == 2'd3) ? 2'd3 : index_e + 2'd1;
					end else begin
						// final byte ends the sequence
						phase_n = acep_pkg::PH_IDLE;
						cmd.move_count = (first_fin != 8'd0) ? first_fin : 8'd1;
						unique case (byte_in)
							acep_pkg::CH_UP: begin
								emit = 1'b1;
								cmd.op = acep_pkg::OP_UP;
							end
							acep_pkg::CH_DOWN: begin
								emit = 1'b1;
								cmd.op = acep_pkg::OP_DOWN;
							end
							acep_pkg::CH_RIGHT: begin
								emit = 1'b1;
								cmd.op = acep_pkg::OP_RIGHT;
							end
							acep_pkg::CH_LEFT: begin
								emit = 1'b1;
								cmd.op = acep_pkg::OP_LEFT;
							end
							acep_pkg::CH_GOTO: begin
								emit = 1'b1;
								cmd.op = acep_pkg::OP_GOTO;
								cmd.goto_column = (first_fin != 8'd0) ? first_fin - 8'd1 : 8'd0;
								cmd.goto_row = (second_fin != 8'd0) ? second_fin - 8'd1 : 8'd0;
							end
							acep_pkg::CH_CLEAR: begin
								emit = 1'b1;
								cmd.op = acep_pkg::OP_CLEAR;
							end
							acep_pkg::CH_EOL: begin
								emit = 1'b1;
								cmd.op = acep_pkg::OP_EOL;
							end
							acep_pkg::CH_SAVE: begin
								emit = 1'b1;
								cmd.op = acep_pkg::OP_SAVE;
							end
							acep_pkg::CH_REST: begin
								emit = 1'b1;
								cmd.op = acep_pkg::OP_RESTORE;
							end
							acep_pkg::CH_SGR: committed_n = sgr_attr;
							default: emit = 1'b0;
						endcase
						if (!(byte_in == acep_pkg::CH_UP || byte_in == acep_pkg::CH_DOWN ||
							byte_in == acep_pkg::CH_RIGHT || byte_in == acep_pkg::CH_LEFT)) begin
							cmd.move_count = 8'd0;
						end
						shadow_n = committed_n;
						field_n  = 8'd0;
						first_n  = 8'd0;
						second_n = 8'd0;
						index_n  = 2'd0;
					end
				end
				default: phase_n = acep_pkg::PH_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/acep_queue.sv =====
module acep_queue #(
	parameter int unsigned Depth = acep_pkg::QueueDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  acep_pkg::cmd_t push_data,
	input  logic           pop,
	output logic           full,
	output logic           empty,
	output acep_pkg::cmd_t head
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	acep_pkg::cmd_t mem [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = (count_q == CntW'(Depth));
	assign empty = (count_q == '0);
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// ===== hdl/acep_back.sv =====
module acep_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           avail,
	input  acep_pkg::cmd_t head,
	output logic           take,
	input  logic           out_ready,
	output logic           out_valid,
	output acep_pkg::cmd_t cmd
);

	logic out_valid_q;
	acep_pkg::cmd_t cmd_q;

	// refill the output register whenever it is empty or being drained
	assign take      = avail && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign cmd       = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= head;
		end
	end

endmodule

// ===== hdl/ansi_escape_command_parser_core.sv =====
// ansi escape parser: turns a byte stream into display commands
// input channel: in_valid/in_ready with byte_in and string_start, one byte per word
// output channel: out_valid/out_ready with op, char_out, move_count, goto_column,
// goto_row and attribute; a byte yields zero or one command word
// the parser front accepts one byte per cycle while the command queue has room;
// a command word passes through the queue and then the output register before it reaches the output
// sustained rate is one byte per cycle while the queue has room, set by the parse step
// the queue of QueueDepth words plus the output register absorbs receiver stalls;
// when the queue is full in_ready drops until the back end drains a word
// bytes that give no command (escape sequence bytes, carriage return) take no
// queue space but still wait while the queue is full
// reset clears the parser to idle, the attribute to white on black, and empties
// the queue and output register; no clearing pass is needed
module ansi_escape_command_parser_core #(
	parameter int unsigned QueueDepth = acep_pkg::QueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] byte_in,
	input  logic       string_start,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] op,
	output logic [7:0] char_out,
	output logic [7:0] move_count,
	output logic [7:0] goto_column,
	output logic [7:0] goto_row,
	output logic [7:0] attribute
);

	logic           accept;
	logic           emit;
	logic           q_full;
	logic           q_empty;
	logic           take;
	acep_pkg::cmd_t front_cmd;
	acep_pkg::cmd_t head;
	acep_pkg::cmd_t out_cmd;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	acep_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.byte_in      (byte_in),
		.string_start (string_start),
		.emit         (emit),
		.cmd          (front_cmd)
	);

	acep_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && emit),
		.push_data (front_cmd),
		.pop       (take),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	acep_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (!q_empty),
		.head      (head),
		.take      (take),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.cmd       (out_cmd)
	);

	assign op          = 4'(out_cmd.op);
	assign char_out    = out_cmd.char_out;
	assign move_count  = out_cmd.move_count;
	assign goto_column = out_cmd.goto_column;
	assign goto_row    = out_cmd.goto_row;
	assign attribute   = out_cmd.attribute;

endmodule
